// ===== rtl/core/dasp_pkg.sv =====
// ----------------------------------------------------------------------------
// dasp_pkg
// shared types, constants, microcode table and arithmetic helpers of the
// dual axis steering pi controller
// ----------------------------------------------------------------------------
package dasp_pkg;

  localparam int SERVO_MIN = 1500;
  localparam int SERVO_MAX = 3000;
  localparam int ANGLE_W   = 16;
  localparam int DT_W      = 16;
  localparam int SERVO_W   = 12;
  localparam int GAIN_W    = 24;
  localparam int KGAIN_W   = 16;
  localparam int INT_W     = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_A_W = 39;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int P33_W   = DT_W + ANGLE_W + 1;
  localparam int SUM_W   = 40;
  localparam int TERM_W  = 38;
  localparam int CMD_W   = 41;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(10);

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FRONT_SLIP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FRONT_YAW  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_REAR_SLIP  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_REAR_YAW   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_MIDPOINT  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_REAR_MIDPOINT   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_YAW_KI          = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_YAW_KP          = CFG_IDX_W'(7);

  localparam logic [SERVO_W-1:0] MIDPOINT_RESET = SERVO_W'(2250);
  localparam logic [KGAIN_W-1:0] KI_RESET       = KGAIN_W'(410);
  localparam logic [KGAIN_W-1:0] KP_RESET       = KGAIN_W'(4096);

  localparam logic signed [SUM_W-1:0] INT32_HI = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] INT32_LO = SUM_W'(-64'sd2147483648);
  localparam logic signed [CMD_W-1:0] CMD_MIN  = CMD_W'(SERVO_MIN);
  localparam logic signed [CMD_W-1:0] CMD_MAX  = CMD_W'(SERVO_MAX);

  typedef struct packed {
    logic        [DT_W-1:0]    time_step;
    logic signed [ANGLE_W-1:0] slip_setpoint;
    logic signed [ANGLE_W-1:0] slip_measured;
    logic signed [ANGLE_W-1:0] yaw_setpoint;
    logic signed [ANGLE_W-1:0] yaw_measured;
  } in_t;

  typedef struct packed {
    logic [SERVO_W-1:0] servo_front;
    logic [SERVO_W-1:0] servo_rear;
    logic [1:0]         clamp_flags;
  } out_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_front_slip;
    logic signed [GAIN_W-1:0] gain_front_yaw;
    logic signed [GAIN_W-1:0] gain_rear_slip;
    logic signed [GAIN_W-1:0] gain_rear_yaw;
    logic        [SERVO_W-1:0] front_midpoint;
    logic        [SERVO_W-1:0] rear_midpoint;
    logic        [KGAIN_W-1:0] yaw_integral_gain;
    logic        [KGAIN_W-1:0] yaw_proportional_gain;
  } cfg_t;

  typedef struct packed {
    logic        [DT_W-1:0]    dt;
    logic signed [ANGLE_W-1:0] slip_err;
    logic signed [ANGLE_W-1:0] yaw_err;
  } op_t;

  typedef enum logic [2:0] {
    A_ZERO     = 3'd0,
    A_SLIP_ERR = 3'd1,
    A_YAW_ERR  = 3'd2,
    A_PROD     = 3'd3,
    A_SLIP_INT = 3'd4,
    A_YAW_TERM = 3'd5
  } sel_a_e;

  typedef enum logic [2:0] {
    B_ZERO = 3'd0,
    B_DT   = 3'd1,
    B_KI   = 3'd2,
    B_KP   = 3'd3,
    B_GFS  = 3'd4,
    B_GFY  = 3'd5,
    B_GRS  = 3'd6,
    B_GRY  = 3'd7
  } sel_b_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_SLIP_ACC  = 3'd1,
    ACT_YAW_ACC   = 3'd2,
    ACT_YAW_TERM  = 3'd3,
    ACT_ACC_LOAD  = 3'd4,
    ACT_ACC_ADD   = 3'd5,
    ACT_FRONT_OUT = 3'd6,
    ACT_REAR_OUT  = 3'd7
  } act_e;

  typedef enum logic [1:0] {
    SEQ_NEXT     = 2'd0,
    SEQ_WAIT_IN  = 2'd1,
    SEQ_WAIT_OUT = 2'd2
  } seq_e;

  typedef struct packed {
    sel_a_e a_sel;
    sel_b_e b_sel;
    act_e   act;
    seq_e   seq;
  } ctrl_t;

  // microcode rom, one control word per step
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{a_sel: A_ZERO, b_sel: B_ZERO, act: ACT_NONE, seq: SEQ_NEXT};
    case (step)
      4'd0: w = '{a_sel: A_ZERO,     b_sel: B_ZERO, act: ACT_NONE,      seq: SEQ_WAIT_IN};
      4'd1: w = '{a_sel: A_SLIP_ERR, b_sel: B_DT,   act: ACT_NONE,      seq: SEQ_NEXT};
      4'd2: w = '{a_sel: A_YAW_ERR,  b_sel: B_DT,   act: ACT_SLIP_ACC,  seq: SEQ_NEXT};
      4'd3: w = '{a_sel: A_PROD,     b_sel: B_KI,   act: ACT_NONE,      seq: SEQ_NEXT};
      4'd4: w = '{a_sel: A_YAW_ERR,  b_sel: B_KP,   act: ACT_YAW_ACC,   seq: SEQ_NEXT};
      4'd5: w = '{a_sel: A_SLIP_INT, b_sel: B_GFS,  act: ACT_YAW_TERM,  seq: SEQ_NEXT};
      4'd6: w = '{a_sel: A_YAW_TERM, b_sel: B_GFY,  act: ACT_ACC_LOAD,  seq: SEQ_NEXT};
      4'd7: w = '{a_sel: A_SLIP_INT, b_sel: B_GRS,  act: ACT_ACC_ADD,   seq: SEQ_NEXT};
      4'd8: w = '{a_sel: A_YAW_TERM, b_sel: B_GRY,  act: ACT_FRONT_OUT, seq: SEQ_NEXT};
      4'd9: w = '{a_sel: A_ZERO,     b_sel: B_ZERO, act: ACT_ACC_ADD,   seq: SEQ_NEXT};
      4'd10: w = '{a_sel: A_ZERO,    b_sel: B_ZERO, act: ACT_REAR_OUT,  seq: SEQ_WAIT_OUT};
      default: w = '{a_sel: A_ZERO,  b_sel: B_ZERO, act: ACT_NONE,      seq: SEQ_WAIT_OUT};
    endcase
    return w;
  endfunction

  function automatic logic signed [INT_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [INT_W-1:0] r;
    r = INT_W'(v);
    if (v > INT32_HI) r = INT_W'(INT32_HI);
    if (v < INT32_LO) r = INT_W'(INT32_LO);
    return r;
  endfunction

  // returns {clamped flag, command}
  function automatic logic [SERVO_W:0] clamp_servo(input logic signed [CMD_W-1:0] v);
    logic signed [CMD_W-1:0] r;
    r = v;
    if (r < CMD_MIN) r = CMD_MIN;
    if (r > CMD_MAX) r = CMD_MAX;
    return {r != v, r[SERVO_W-1:0]};
  endfunction

endpackage

// ===== rtl/core/dasp_datapath.sv =====
// ----------------------------------------------------------------------------
// dasp_datapath
// shared signed multiplier, integrators, accumulator and servo clamp,
// driven one control word per cycle by the sequencer
// ----------------------------------------------------------------------------
module dasp_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dasp_pkg::ctrl_t ctrl_i,
  input  dasp_pkg::cfg_t  cfg_i,
  input  dasp_pkg::op_t   op_i,
  output dasp_pkg::out_t  res_o
);
  import dasp_pkg::*;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [P33_W-1:0]   prod33;

  logic signed [INT_W-1:0]   slip_int_d, slip_int_q;
  logic signed [INT_W-1:0]   yaw_int_d, yaw_int_q;
  logic signed [TERM_W-1:0]  yaw_term_d, yaw_term_q;
  logic signed [PROD_W-1:0]  acc_d, acc_q;
  logic [SERVO_W:0]          front_d, front_q;

  logic signed [SUM_W-1:0]   slip_sum, yaw_sum;
  logic signed [PROD_W-1:0]  yaw_rnd, yaw_inc, eff_rnd;
  logic signed [TERM_W-1:0]  term_p;
  logic [SERVO_W-1:0]        mid;
  logic signed [CMD_W-1:0]   cmd;
  logic [SERVO_W:0]          clamped;

  assign prod33 = prod_q[P33_W-1:0];

  always_comb begin
    case (ctrl_i.a_sel)
      A_SLIP_ERR: mul_a = MUL_A_W'(op_i.slip_err);
      A_YAW_ERR:  mul_a = MUL_A_W'(op_i.yaw_err);
      A_PROD:     mul_a = MUL_A_W'(prod33);
      A_SLIP_INT: mul_a = MUL_A_W'(slip_int_q);
      A_YAW_TERM: mul_a = MUL_A_W'(yaw_term_q);
      default:    mul_a = '0;
    endcase
    case (ctrl_i.b_sel)
      B_DT:    mul_b = MUL_B_W'($signed({1'b0, op_i.dt}));
      B_KI:    mul_b = MUL_B_W'($signed({1'b0, cfg_i.yaw_integral_gain}));
      B_KP:    mul_b = MUL_B_W'($signed({1'b0, cfg_i.yaw_proportional_gain}));
      B_GFS:   mul_b = MUL_B_W'(cfg_i.gain_front_slip);
      B_GFY:   mul_b = MUL_B_W'(cfg_i.gain_front_yaw);
      B_GRS:   mul_b = MUL_B_W'(cfg_i.gain_rear_slip);
      B_GRY:   mul_b = MUL_B_W'(cfg_i.gain_rear_yaw);
      default: mul_b = '0;
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // integrator and term arithmetic
  assign slip_sum = SUM_W'(slip_int_q) + SUM_W'(prod33);
  assign yaw_rnd  = prod_q + PROD_W'(2048);
  assign yaw_inc  = yaw_rnd >>> 12;
  assign yaw_sum  = SUM_W'(yaw_int_q) + SUM_W'(yaw_inc);
  assign term_p   = TERM_W'(prod33);

  // effort rounding, midpoint offset and clamp
  assign mid     = (ctrl_i.act == ACT_REAR_OUT) ? cfg_i.rear_midpoint : cfg_i.front_midpoint;
  assign eff_rnd = (acc_q + PROD_W'(64'sd8388608)) >>> 24;
  assign cmd     = CMD_W'(eff_rnd) + CMD_W'($signed({1'b0, mid}));
  assign clamped = clamp_servo(cmd);

  always_comb begin
    slip_int_d = slip_int_q;
    yaw_int_d  = yaw_int_q;
    yaw_term_d = yaw_term_q;
    acc_d      = acc_q;
    front_d    = front_q;
    case (ctrl_i.act)
      ACT_SLIP_ACC:  slip_int_d = sat32(slip_sum);
      ACT_YAW_ACC:   yaw_int_d  = sat32(yaw_sum);
      ACT_YAW_TERM:  yaw_term_d = TERM_W'(yaw_int_q) + (term_p <<< 4);
      ACT_ACC_LOAD:  acc_d      = prod_q;
      ACT_ACC_ADD:   acc_d      = acc_q + prod_q;
      ACT_FRONT_OUT: begin
        front_d = clamped;
        acc_d   = prod_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slip_int_q <= '0;
      yaw_int_q  <= '0;
    end else begin
      slip_int_q <= slip_int_d;
      yaw_int_q  <= yaw_int_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    yaw_term_q <= yaw_term_d;
    acc_q      <= acc_d;
    front_q    <= front_d;
  end

  assign res_o.servo_front = front_q[SERVO_W-1:0];
  assign res_o.servo_rear  = clamped[SERVO_W-1:0];
  assign res_o.clamp_flags = {clamped[SERVO_W], front_q[SERVO_W]};

endmodule

// ===== rtl/core/dual_axis_steering_pi_controller_top.sv =====
// ----------------------------------------------------------------------------
// dual_axis_steering_pi_controller_top
// two axis steering pi controller: microcoded sequencer over one shared
// multiplier, with configuration registers and item handshakes
// ----------------------------------------------------------------------------
// sequencing: an accepted item runs the eleven microcode steps, which share a
//   single 39x25 multiplier; no new item is taken until the program returns
//   to the idle step, and the last step holds while a result waits
// reset: asynchronous, active low; integrators cleared, registers to defaults
module dual_axis_steering_pi_controller_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dasp_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dasp_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [dasp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dasp_pkg::CFG_W-1:0]          cfg_data_i
);
  import dasp_pkg::*;

  logic [STEP_W-1:0] step_d, step_q;
  ctrl_t             uc;
  cfg_t              cfg_q;
  op_t               op_q;
  out_t              res, out_q;
  logic              out_valid_d, out_valid_q;
  logic              in_fire, out_busy, finish;

  assign uc         = ucode(step_q);
  assign in_ready_o = (uc.seq == SEQ_WAIT_IN);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign finish     = (uc.seq == SEQ_WAIT_OUT) && !out_busy;

  always_comb begin
    step_d = step_q;
    case (uc.seq)
      SEQ_NEXT:     step_d = step_q + STEP_W'(1);
      SEQ_WAIT_IN:  if (in_valid_i) step_d = step_q + STEP_W'(1);
      SEQ_WAIT_OUT: if (!out_busy) step_d = STEP_IDLE;
      default:      step_d = STEP_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_front_slip       <= '0;
      cfg_q.gain_front_yaw        <= '0;
      cfg_q.gain_rear_slip        <= '0;
      cfg_q.gain_rear_yaw         <= '0;
      cfg_q.front_midpoint        <= MIDPOINT_RESET;
      cfg_q.rear_midpoint         <= MIDPOINT_RESET;
      cfg_q.yaw_integral_gain     <= KI_RESET;
      cfg_q.yaw_proportional_gain <= KP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GAIN_FRONT_SLIP: cfg_q.gain_front_slip <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_GAIN_FRONT_YAW:  cfg_q.gain_front_yaw  <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_GAIN_REAR_SLIP:  cfg_q.gain_rear_slip  <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_GAIN_REAR_YAW:   cfg_q.gain_rear_yaw   <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_FRONT_MIDPOINT:  cfg_q.front_midpoint  <= cfg_data_i[SERVO_W-1:0];
        REG_REAR_MIDPOINT:   cfg_q.rear_midpoint   <= cfg_data_i[SERVO_W-1:0];
        REG_YAW_KI:          cfg_q.yaw_integral_gain     <= cfg_data_i[KGAIN_W-1:0];
        REG_YAW_KP:          cfg_q.yaw_proportional_gain <= cfg_data_i[KGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // angle errors wrap at the field width
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q.dt       <= in_data_i.time_step;
      op_q.slip_err <= in_data_i.slip_setpoint - in_data_i.slip_measured;
      op_q.yaw_err  <= in_data_i.yaw_setpoint - in_data_i.yaw_measured;
    end
    if (finish) begin
      out_q <= res;
    end
  end

  dasp_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (uc),
    .cfg_i  (cfg_q),
    .op_i   (op_q),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_LAST)
    else $error("step counter out of program");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (step_q == STEP_IDLE + STEP_W'(1)) && !in_ready_o)
    else $error("accepted item did not start the program");

  a_finish_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_o && in_ready_o)
    else $error("finished item not presented");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_LAST) && out_busy |=> step_q == STEP_LAST)
    else $error("sequencer left last step while result pending");

endmodule

// ===== bench/dasp_tick_checker.sv =====
// ----------------------------------------------------------------------------
// dasp_tick_checker
// Watches the control tick and servo command channels of the dual axis
// steering pi controller. It tracks register writes, keeps its own slip and
// yaw integrators and works out the servo commands and clamp flags of every
// accepted tick. Each accepted command is compared field by field with the
// oldest prediction. Failures are counted and handed to the bench top.
// ----------------------------------------------------------------------------
module dasp_tick_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  dasp_pkg::in_t                  in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  dasp_pkg::out_t                 out_data_i,
  input  logic                           cfg_we_i,
  input  logic [dasp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dasp_pkg::CFG_W-1:0]     cfg_data_i,
  output int                             mismatch_count_o,
  output int                             pending_o
);
  import dasp_pkg::*;

  logic signed [GAIN_W-1:0] k_front_slip = '0;
  logic signed [GAIN_W-1:0] k_front_yaw  = '0;
  logic signed [GAIN_W-1:0] k_rear_slip  = '0;
  logic signed [GAIN_W-1:0] k_rear_yaw   = '0;
  logic [SERVO_W-1:0]       mid_front    = MIDPOINT_RESET;
  logic [SERVO_W-1:0]       mid_rear     = MIDPOINT_RESET;
  logic [KGAIN_W-1:0]       yaw_ki       = KI_RESET;
  logic [KGAIN_W-1:0]       yaw_kp       = KP_RESET;

  longint slip_acc = 0;
  longint yaw_acc  = 0;
  out_t   cmd_q[$];
  out_t   want_cmd;
  out_t   got_cmd;
  int     mismatches = 0;

  function automatic logic signed [ANGLE_W-1:0] wrapped_err(
    input logic signed [ANGLE_W-1:0] sp,
    input logic signed [ANGLE_W-1:0] ms
  );
    return sp - ms;
  endfunction

  function automatic longint sat_int32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // {clamped, command}
  function automatic logic [SERVO_W:0] clamp_cmd(input longint v);
    longint r;
    r = v;
    if (r < SERVO_MIN) r = SERVO_MIN;
    if (r > SERVO_MAX) r = SERVO_MAX;
    return {r != v, r[SERVO_W-1:0]};
  endfunction

  task automatic predict_servo(input in_t t, output out_t o);
    longint dt, slip_e, yaw_e, ki, kp, yaw_sum, eff_f, eff_r;
    longint gfs, gfy, grs, gry, midf, midr;
    logic [SERVO_W:0] cf, cr;
    dt      = t.time_step;
    slip_e  = wrapped_err(t.slip_setpoint, t.slip_measured);
    yaw_e   = wrapped_err(t.yaw_setpoint, t.yaw_measured);
    ki      = yaw_ki;
    kp      = yaw_kp;
    gfs     = k_front_slip;
    gfy     = k_front_yaw;
    grs     = k_rear_slip;
    gry     = k_rear_yaw;
    midf    = mid_front;
    midr    = mid_rear;
    slip_acc = sat_int32(slip_acc + dt * slip_e);
    yaw_acc  = sat_int32(yaw_acc + ((dt * yaw_e * ki + 64'sd2048) >>> 12));
    yaw_sum  = yaw_acc + kp * yaw_e * 16;
    eff_f = ((gfs * slip_acc + gfy * yaw_sum + (64'sd1 <<< 23)) >>> 24) + midf;
    eff_r = ((grs * slip_acc + gry * yaw_sum + (64'sd1 <<< 23)) >>> 24) + midr;
    cf = clamp_cmd(eff_f);
    cr = clamp_cmd(eff_r);
    o.servo_front = cf[SERVO_W-1:0];
    o.servo_rear  = cr[SERVO_W-1:0];
    o.clamp_flags = {cr[SERVO_W], cf[SERVO_W]};
  endtask

  task automatic check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_front_slip = '0;
      k_front_yaw  = '0;
      k_rear_slip  = '0;
      k_rear_yaw   = '0;
      mid_front    = MIDPOINT_RESET;
      mid_rear     = MIDPOINT_RESET;
      yaw_ki       = KI_RESET;
      yaw_kp       = KP_RESET;
      slip_acc     = 0;
      yaw_acc      = 0;
      cmd_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_GAIN_FRONT_SLIP: k_front_slip = cfg_data_i[GAIN_W-1:0];
          REG_GAIN_FRONT_YAW:  k_front_yaw  = cfg_data_i[GAIN_W-1:0];
          REG_GAIN_REAR_SLIP:  k_rear_slip  = cfg_data_i[GAIN_W-1:0];
          REG_GAIN_REAR_YAW:   k_rear_yaw   = cfg_data_i[GAIN_W-1:0];
          REG_FRONT_MIDPOINT:  mid_front    = cfg_data_i[SERVO_W-1:0];
          REG_REAR_MIDPOINT:   mid_rear     = cfg_data_i[SERVO_W-1:0];
          REG_YAW_KI:          yaw_ki       = cfg_data_i[KGAIN_W-1:0];
          REG_YAW_KP:          yaw_kp       = cfg_data_i[KGAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got_cmd = out_data_i;
        if (cmd_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: servo command with none predicted: front %0d rear %0d flags %0d",
                     $time, got_cmd.servo_front, got_cmd.servo_rear, got_cmd.clamp_flags);
        end else begin
          want_cmd = cmd_q.pop_front();
          check_field("servo_front", want_cmd.servo_front, got_cmd.servo_front);
          check_field("servo_rear", want_cmd.servo_rear, got_cmd.servo_rear);
          check_field("clamp_flags", want_cmd.clamp_flags, got_cmd.clamp_flags);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_servo(in_data_i, want_cmd);
        cmd_q.push_back(want_cmd);
      end
      pending_o <= cmd_q.size();
    end
    mismatch_count_o <= mismatches;
  end

endmodule

// ===== bench/tb_dual_axis_steering_pi_controller_top.sv =====
// ----------------------------------------------------------------------------
// tb_dual_axis_steering_pi_controller_top
// Drives control ticks into the steering pi controller under a series of
// register settings and handshake idling patterns: a directed set of
// angle wrap, zero time step and integrator saturation ticks, then random
// ticks. Includes a long output hold-off that backs up the input. A side
// checker predicts every servo command; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dual_axis_steering_pi_controller_top;
  import dasp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 12;
  localparam int PHASE_TICKS    = 112;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_t                 out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int   mismatch_count;
  int   pending;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  int   quiet_cycles   = 0;

  dual_axis_steering_pi_controller_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  dasp_tick_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // command receiver, with an optional long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_t mk_tick(input int dt, input int ss, input int sm,
                                  input int ys, input int ym);
    in_t t;
    t.time_step     = DT_W'(dt);
    t.slip_setpoint = ANGLE_W'(ss);
    t.slip_measured = ANGLE_W'(sm);
    t.yaw_setpoint  = ANGLE_W'(ys);
    t.yaw_measured  = ANGLE_W'(ym);
    return t;
  endfunction

  function automatic in_t random_tick();
    in_t t;
    case ($urandom_range(9))
      0:          t.time_step = '0;
      1, 2, 3, 4: t.time_step = DT_W'($urandom_range(255));
      5, 6:       t.time_step = DT_W'($urandom_range(4095));
      default:    t.time_step = DT_W'($urandom);
    endcase
    t.slip_setpoint = ANGLE_W'($urandom);
    t.yaw_setpoint  = ANGLE_W'($urandom);
    if ($urandom_range(3) == 0) begin
      t.slip_measured = ANGLE_W'($urandom);
      t.yaw_measured  = ANGLE_W'($urandom);
    end else begin
      t.slip_measured = t.slip_setpoint + ANGLE_W'($urandom_range(512)) - ANGLE_W'(256);
      t.yaw_measured  = t.yaw_setpoint + ANGLE_W'($urandom_range(512)) - ANGLE_W'(256);
    end
    return t;
  endfunction

  function automatic logic signed [GAIN_W-1:0] random_gain();
    case ($urandom_range(2))
      0:       return GAIN_W'($urandom_range(128)) - GAIN_W'(64);
      1:       return GAIN_W'($urandom_range(131072)) - GAIN_W'(65536);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [SERVO_W-1:0] random_midpoint();
    if ($urandom_range(1) == 0) return SERVO_W'($urandom_range(SERVO_MAX, SERVO_MIN));
    return SERVO_W'($urandom);
  endfunction

  function automatic logic [KGAIN_W-1:0] random_kgain();
    if ($urandom_range(1) == 0) return KGAIN_W'($urandom_range(8192));
    return KGAIN_W'($urandom);
  endfunction

  // valid stays high into the next item unless an idle gap is drawn
  task automatic send_tick(input in_t t);
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic write_config(input cfg_t c);
    write_reg(REG_GAIN_FRONT_SLIP, c.gain_front_slip);
    write_reg(REG_GAIN_FRONT_YAW, c.gain_front_yaw);
    write_reg(REG_GAIN_REAR_SLIP, c.gain_rear_slip);
    write_reg(REG_GAIN_REAR_YAW, c.gain_rear_yaw);
    write_reg(REG_FRONT_MIDPOINT, {(CFG_W-SERVO_W)'($urandom), c.front_midpoint});
    write_reg(REG_REAR_MIDPOINT, {(CFG_W-SERVO_W)'($urandom), c.rear_midpoint});
    write_reg(REG_YAW_KI, {(CFG_W-KGAIN_W)'($urandom), c.yaw_integral_gain});
    write_reg(REG_YAW_KP, {(CFG_W-KGAIN_W)'($urandom), c.yaw_proportional_gain});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    cfg_t cfg;
    int   p;
    int   k;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_GAIN_FRONT_SLIP;
    cfg_data_i  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero gains, commands sit at the midpoint
    send_tick(mk_tick(0, 0, 0, 0, 0));
    send_tick(mk_tick(65535, 32767, -32768, -32768, 32767));
    send_tick(mk_tick(1234, 100, -100, 200, -200));
    drain();

    cfg.gain_front_slip       = 24'sd4096;
    cfg.gain_front_yaw        = -24'sd2048;
    cfg.gain_rear_slip        = -24'sd4096;
    cfg.gain_rear_yaw         = 24'sd1024;
    cfg.front_midpoint        = 12'd2250;
    cfg.rear_midpoint         = 12'd2000;
    cfg.yaw_integral_gain     = 16'd4096;
    cfg.yaw_proportional_gain = 16'd4096;
    write_config(cfg);

    // zero time step, angle wrap, then saturation of both integrators
    send_tick(mk_tick(0, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 0, 50, 0));
    send_tick(mk_tick(1000, 500, -500, -30, 0));
    send_tick(mk_tick(65535, 32767, -32768, 0, 0));
    send_tick(mk_tick(65535, -32768, 32767, 0, 0));
    send_tick(mk_tick(300, -32768, 0, 0, -32768));
    send_tick(mk_tick(0, 32767, -32768, -32768, 32767));
    for (k = 0; k < 3; k++) send_tick(mk_tick(65535, 16383, -16384, 16383, -16384));
    for (k = 0; k < 5; k++) send_tick(mk_tick(65535, -16384, 16384, -16384, 16384));
    send_tick(mk_tick(65535, 32767, 32767, -32768, -32768));
    send_tick(mk_tick(1, 1, 0, -1, 0));
    send_tick(mk_tick(65535, 0, 0, 0, 0));
    drain();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          cfg.gain_front_slip       = 24'sh7fffff;
          cfg.gain_front_yaw        = 24'sh800000;
          cfg.gain_rear_slip        = 24'sh800000;
          cfg.gain_rear_yaw         = 24'sh7fffff;
          cfg.front_midpoint        = 12'd4095;
          cfg.rear_midpoint         = 12'd0;
          cfg.yaw_integral_gain     = 16'hffff;
          cfg.yaw_proportional_gain = 16'hffff;
        end
        1: begin
          cfg.gain_front_slip       = 24'sh800000;
          cfg.gain_front_yaw        = 24'sh7fffff;
          cfg.gain_rear_slip        = 24'sh7fffff;
          cfg.gain_rear_yaw         = 24'sh800000;
          cfg.front_midpoint        = 12'd0;
          cfg.rear_midpoint         = 12'd4095;
          cfg.yaw_integral_gain     = '0;
          cfg.yaw_proportional_gain = '0;
        end
        default: begin
          cfg.gain_front_slip       = random_gain();
          cfg.gain_front_yaw        = random_gain();
          cfg.gain_rear_slip        = random_gain();
          cfg.gain_rear_yaw         = random_gain();
          cfg.front_midpoint        = random_midpoint();
          cfg.rear_midpoint         = random_midpoint();
          cfg.yaw_integral_gain     = random_kgain();
          cfg.yaw_proportional_gain = random_kgain();
        end
      endcase
      write_config(cfg);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      // back up the block behind a long output hold-off
      if (p == 4) hold_req = 1'b1;
      for (k = 0; k < PHASE_TICKS; k++) send_tick(random_tick());
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dasp_pkg.sv
rtl/core/dasp_datapath.sv
rtl/core/dual_axis_steering_pi_controller_top.sv
bench/dasp_tick_checker.sv
bench/tb_dual_axis_steering_pi_controller_top.sv
